[rtl/core/albdu_pkg.sv]
`timescale 1ns / 1ps
package albdu_pkg;

	// stream widths
	localparam int S_TDATA_W = 120;
	localparam int M_TDATA_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BARE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRESH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_OBS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IPD     = 3'd4;

	// configuration reset values
	localparam logic [15:0] BARE_RST  = 16'd11141;
	localparam logic [15:0] FRESH_RST = 16'd55705;
	localparam logic [8:0]  IPD_RST   = 9'd24;

	// saturation limits
	localparam logic [19:0] SUM_MAX = 20'hFFFFF;
	localparam logic [7:0]  AGE_MAX = 8'hFF;

	// snow water thresholds (0.1 mm)
	localparam logic [15:0] SWE_SNOW = 16'd50;
	localparam logic [15:0] SWE_DEEP = 16'd600;
	localparam logic [19:0] SUM_MIN  = 20'd25;

	// smallest q0.16 albedo above 0.65
	localparam logic [15:0] ALB_065 = 16'd42599;

	// albedo decrements in q0.16
	localparam logic [12:0] DEC_MELT    = 13'd4653;
	localparam logic [12:0] DEC_DEEP_HI = 13'd983;
	localparam logic [12:0] DEC_DEEP_LO = 13'd66;
	localparam logic [12:0] DEC_FRESH   = 13'd3277;
	localparam logic [12:0] DEC_SUMMER  = 13'd1311;
	localparam logic [12:0] DEC_COLD    = 13'd393;

	// net radiation constants
	localparam logic [9:0]  RAD_GAIN = 10'd522;
	localparam logic [21:0] RAD_RND  = 22'd3276800;
	localparam logic [8:0]  QNC_OFS  = 9'd371;

	// reciprocals floor(2^32 / d)
	localparam logic [25:0] RCP_100 = 26'd42949672;
	localparam logic [25:0] RCP_125 = 26'd34359738;

	// item classes decided by the front
	typedef enum logic [1:0] {
		CLS_INIT,
		CLS_ACCUM,
		CLS_DAY_END,
		CLS_DROP
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic               new_day;
		logic [5:0]         unit;
		logic [8:0]         day;
		logic [15:0]        swe;
		logic [15:0]        fall;
		logic               new_snow;
		logic signed [13:0] tmax;
		logic signed [13:0] tmin;
		logic [15:0]        rad;
		logic [15:0]        obs;
	} cmd_t;

	typedef struct packed {
		logic [15:0] bare;
		logic [15:0] fresh;
		logic        south;
		logic        use_obs;
		logic [8:0]  ipd;
	} cfg_t;

	// per unit state, albedo in the low bits
	typedef struct packed {
		logic [7:0]  age;
		logic [19:0] sum;
		logic        melt;
		logic        winter;
		logic [15:0] albedo;
	} st_t;

	localparam int ST_W = $bits(st_t);

endpackage

[rtl/core/snow_albedo_daily_update.sv]
`timescale 1ns / 1ps
// Snow albedo daily update for a set of land units.
// Input stream s_*: one item per transfer; s_tuser is the kind (0 init unit,
// 1 advance one interval). Output stream m_*: exactly one result per item,
// the addressed unit's state after the update (zero for an out of range unit), in input order.
// Configuration: cfg_we with cfg_index and cfg_data writes one register per
// cycle; write it only while no item is in flight.
// Init and mid-day items pass the back end states idle, C1 and done; an item
// that closes a day also passes C2, C3 and C4 before done. Items are processed
// one at a time by the back end sequencer, which takes the next item only once
// the last result has moved into the output register; the radiation and
// snowfall divisions run in the extra states C2 to C4 of the back end.
// A two entry queue sits between the accepting front and the back end, so
// new items are taken while a result waits in the output register.
// When m_tready is low the result holds and the back end waits; the queue
// then fills and s_tready drops.
// Reset clears the control state and loads the configuration defaults; the
// unit state memory is not cleared, so every unit needs an init item first.
module snow_albedo_daily_update #(
	parameter int NUM_UNITS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// unit, interval_in_day, day_of_year, snow_water, interval_snowfall,
	// new_snow, max_temperature, min_temperature, direct_radiation,
	// observed_albedo
	input  logic [albdu_pkg::S_TDATA_W-1:0]  s_tdata,
	// kind
	input  logic                             s_tuser,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// albedo, winter_flag, melt_flag, daily_snowfall, days_since_snow
	output logic [albdu_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             cfg_we,
	input  logic [albdu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [albdu_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import albdu_pkg::*;

	localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

	cfg_t          cfg_q;
	logic          q_full;
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	logic          q_valid;
	cmd_t          q_cmd;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [ST_W-1:0] rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [ST_W-1:0] wr_data;
	st_t           res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bare    <= BARE_RST;
			cfg_q.fresh   <= FRESH_RST;
			cfg_q.south   <= 1'b0;
			cfg_q.use_obs <= 1'b0;
			cfg_q.ipd     <= IPD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BARE:    cfg_q.bare    <= cfg_data;
				CFG_FRESH:   cfg_q.fresh   <= cfg_data;
				CFG_SOUTH:   cfg_q.south   <= cfg_data[0];
				CFG_USE_OBS: cfg_q.use_obs <= cfg_data[0];
				CFG_IPD:     cfg_q.ipd     <= cfg_data[8:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	albdu_front #(.NUM_UNITS(NUM_UNITS)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	albdu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_cmd  (q_cmd)
	);

	albdu_back #(.NUM_UNITS(NUM_UNITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (res)
	);

	albdu_ram #(.WIDTH(ST_W), .DEPTH(NUM_UNITS)) u_state_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign m_tdata = {(M_TDATA_W - ST_W)'(0), res};
endmodule

[rtl/core/albdu_ram.sv]
`timescale 1ns / 1ps
module albdu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

[rtl/core/albdu_front.sv]
`timescale 1ns / 1ps
module albdu_front #(
	parameter int NUM_UNITS = 64
) (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [albdu_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tuser,
	input  albdu_pkg::cfg_t                  cfg,
	input  logic                             q_full,
	output logic                             push,
	output albdu_pkg::cmd_t                  push_cmd
);
	import albdu_pkg::*;

	logic [5:0] unit_in;
	logic [8:0] step_in;
	logic       one_per_day;
	logic       day_end;
	logic       in_range;

	// take a transfer whenever the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// classify the item
	always_comb begin
		unit_in     = s_tdata[5:0];
		step_in     = s_tdata[14:6];
		one_per_day = (cfg.ipd == 9'd1);
		day_end     = (step_in == 9'd0) || one_per_day;
		in_range    = (32'(unit_in) < NUM_UNITS);

		push_cmd          = '0;
		push_cmd.new_day  = (step_in == 9'd1) || one_per_day;
		push_cmd.unit     = unit_in;
		push_cmd.day      = s_tdata[23:15];
		push_cmd.swe      = s_tdata[39:24];
		push_cmd.fall     = s_tdata[55:40];
		push_cmd.new_snow = s_tdata[56];
		push_cmd.tmax     = s_tdata[70:57];
		push_cmd.tmin     = s_tdata[84:71];
		push_cmd.rad      = s_tdata[100:85];
		push_cmd.obs      = s_tdata[116:101];

		if (!in_range) begin
			push_cmd.cls = CLS_DROP;
		end else if (!s_tuser) begin
			push_cmd.cls = CLS_INIT;
		end else if (day_end) begin
			push_cmd.cls = CLS_DAY_END;
		end else begin
			push_cmd.cls = CLS_ACCUM;
		end
	end
endmodule

[rtl/core/albdu_queue.sv]
`timescale 1ns / 1ps
module albdu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  albdu_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output albdu_pkg::cmd_t pop_cmd
);
	import albdu_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign valid   = (count_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

[rtl/core/albdu_back.sv]
`timescale 1ns / 1ps
module albdu_back #(
	parameter int NUM_UNITS = 64
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  albdu_pkg::cfg_t                                  cfg,
	input  logic                                             q_valid,
	input  albdu_pkg::cmd_t                                  q_cmd,
	output logic                                             pop,
	output logic                                             rd_en,
	output logic [((NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1)-1:0] rd_addr,
	input  logic [albdu_pkg::ST_W-1:0]                       rd_data,
	output logic                                             wr_en,
	output logic [((NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1)-1:0] wr_addr,
	output logic [albdu_pkg::ST_W-1:0]                       wr_data,
	output logic                                             m_valid,
	input  logic                                             m_ready,
	output albdu_pkg::st_t                                   m_res
);
	import albdu_pkg::*;

	localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_valid_q;

	// working registers
	cmd_t               cmd_q;
	st_t                pre_q;
	logic [15:0]        a0_q;
	logic               w0_q;
	logic [7:0]         age_q;
	logic [19:0]        sum_q;
	logic [32:0]        m1_q;
	logic [26:0]        y_q;
	logic [13:0]        qsa_q;
	logic [20:0]        qa_q;
	logic [13:0]        qs_q;
	logic [20:0]        v_q;
	logic signed [21:0] qnc_q;
	logic [14:0]        va_q;
	st_t                res_q;

	// first stage signals
	st_t         st_rd;
	logic [20:0] sum_add;
	logic [19:0] sum_n;
	logic        season;
	logic        snow_in;
	logic [15:0] a0;
	logic        w0;
	logic [7:0]  age_n;
	logic [32:0] m1;
	st_t         pre;

	// divider stage signals
	logic [42:0] p_rad;
	logic [45:0] qsa_prod;
	logic [52:0] qa_prod;
	logic [20:0] rs_try;
	logic [13:0] qs;
	logic [6:0]  rs;
	logic [27:0] rq;
	logic [20:0] q_fix;
	logic [46:0] va_prod;

	// final stage signals
	logic [21:0]        rv;
	logic [14:0]        vq;
	logic [28:0]        inc;
	logic [28:0]        a_sum;
	logic               mc;
	logic               cold;
	logic               w1;
	logic               melt1;
	logic signed [19:0] tmax_x10;
	logic signed [19:0] mt_lim;
	logic [12:0]        dr;
	logic [12:0]        dec;
	logic [15:0]        a1;
	logic signed [17:0] a2;
	logic signed [17:0] a3;
	st_t                fin;
	st_t                done_res;
	logic               fire;

	assign st_rd   = st_t'(rd_data);
	assign pop     = (state_q == ST_IDLE) && q_valid;
	assign rd_en   = pop;
	assign rd_addr = AW'(q_cmd.unit);
	assign fire    = (state_q == ST_DONE) && (!m_valid_q || m_ready);
	assign m_valid = m_valid_q;
	assign m_res   = res_q;

	// first stage: sum, season, age and radiation product
	always_comb begin
		sum_add = 21'(st_rd.sum) + 21'(cmd_q.fall);
		if (cmd_q.new_day) begin
			sum_n = 20'(cmd_q.fall);
		end else if (sum_add > 21'(SUM_MAX)) begin
			sum_n = SUM_MAX;
		end else begin
			sum_n = sum_add[19:0];
		end

		if (cfg.south) begin
			season = (cmd_q.day > 9'd117) && (cmd_q.day < 9'd185);
		end else begin
			season = (cmd_q.day > 9'd300) || (cmd_q.day < 9'd2);
		end
		snow_in = (cmd_q.swe > SWE_SNOW);
		a0      = (season && snow_in) ? cfg.fresh : st_rd.albedo;
		w0      = (season && snow_in) ? 1'b1 : st_rd.winter;

		if (cmd_q.new_snow) begin
			age_n = '0;
		end else if (st_rd.age < AGE_MAX) begin
			age_n = st_rd.age + 8'd1;
		end else begin
			age_n = st_rd.age;
		end

		m1 = 33'(cmd_q.rad) * (33'(17'h10000) - 33'(a0));

		// results that need no day end work
		pre = '0;
		case (cmd_q.cls)
			CLS_INIT: begin
				pre.albedo = snow_in ? cfg.fresh : cfg.bare;
				pre.winter = snow_in;
			end
			CLS_ACCUM: begin
				pre     = st_rd;
				pre.sum = sum_n;
			end
			default: pre = '0;
		endcase
	end

	// divider stages by reciprocal and one correction
	always_comb begin
		p_rad    = 43'(m1_q) * 43'(RAD_GAIN) + 43'(RAD_RND);
		qsa_prod = 46'(sum_q) * 46'(RCP_125);
		qa_prod  = 53'(y_q) * 53'(RCP_100);

		rs_try = 21'(sum_q) - 21'(qsa_q) * 21'd125;
		if (rs_try >= 21'd125) begin
			qs = qsa_q + 14'd1;
			rs = 7'(rs_try - 21'd125);
		end else begin
			qs = qsa_q;
			rs = 7'(rs_try);
		end

		rq = 28'(y_q) - 28'(qa_q) * 28'd100;
		q_fix   = (rq >= 28'd100) ? qa_q + 21'd1 : qa_q;
		va_prod = 47'(v_q) * 47'(RCP_125);
	end

	// final stage: melt test, albedo aging and limits
	always_comb begin
		rv  = 22'(v_q) - 22'(va_q) * 22'd125;
		vq  = (rv >= 22'd125) ? va_q + 15'd1 : va_q;
		inc = 29'(qs_q) * 29'd16384 + 29'(vq);

		tmax_x10 = 20'(cmd_q.tmax) * 20'sd10;
		mt_lim   = 20'sd6690 - 20'sd64 * $signed({11'd0, cmd_q.day});
		mc = (cmd_q.tmin > -14'sd400) ||
			((qnc_q > 22'sd1000) && (cmd_q.tmax > 14'sd0)) ||
			((tmax_x10 > mt_lim) && (qnc_q > -22'sd500));
		cold  = (cmd_q.tmax < -14'sd600) && (qnc_q < 22'sd1000);
		w1    = w0_q || cold;
		melt1 = cold && mc;

		if (cmd_q.swe > SWE_DEEP) begin
			dr = (a0_q >= ALB_065) ? DEC_DEEP_HI : DEC_DEEP_LO;
		end else begin
			dr = DEC_MELT;
		end

		a_sum = 29'(a0_q) + inc;
		if (sum_q > SUM_MIN) begin
			a1 = (a_sum > 29'(cfg.fresh)) ? cfg.fresh : a_sum[15:0];
		end else begin
			a1 = a0_q;
		end

		if (!w1) begin
			dec = DEC_SUMMER;
		end else if (age_q < 8'd3) begin
			dec = DEC_FRESH;
		end else if (mc) begin
			dec = dr;
		end else if (a1 >= ALB_065) begin
			dec = DEC_COLD;
		end else begin
			dec = '0;
		end

		if (cfg.use_obs) begin
			a2 = $signed({2'd0, cmd_q.obs});
		end else begin
			a2 = $signed({2'd0, a1}) - $signed({5'd0, dec});
		end

		fin     = '0;
		fin.sum = sum_q;
		fin.age = age_q;
		if (cmd_q.swe == 16'd0) begin
			a3         = $signed({2'd0, cfg.bare});
			fin.winter = 1'b0;
			fin.melt   = 1'b0;
		end else if (!w1) begin
			a3         = (a2 < $signed({2'd0, cfg.bare})) ? $signed({2'd0, cfg.bare}) : a2;
			fin.winter = 1'b0;
			fin.melt   = 1'b1;
		end else begin
			a3         = a2;
			fin.winter = 1'b1;
			fin.melt   = melt1;
		end
		fin.albedo = (a3 < 18'sd0) ? 16'd0 : a3[15:0];

		done_res = (cmd_q.cls == CLS_DAY_END) ? fin : pre_q;
	end

	// state write back on the final cycle
	assign wr_en   = fire && (cmd_q.cls != CLS_DROP);
	assign wr_addr = AW'(cmd_q.unit);
	assign wr_data = done_res;

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (q_valid) state_q <= ST_C1;
				ST_C1:   state_q <= (cmd_q.cls == CLS_DAY_END) ? ST_C2 : ST_DONE;
				ST_C2:   state_q <= ST_C3;
				ST_C3:   state_q <= ST_C4;
				ST_C4:   state_q <= ST_DONE;
				ST_DONE: if (fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_C1) begin
			pre_q <= pre;
			a0_q  <= a0;
			w0_q  <= w0;
			age_q <= age_n;
			sum_q <= sum_n;
			m1_q  <= m1;
		end
		if (state_q == ST_C2) begin
			y_q   <= p_rad[42:16];
			qsa_q <= qsa_prod[45:32];
		end
		if (state_q == ST_C3) begin
			qa_q <= qa_prod[52:32];
			qs_q <= qs;
			v_q  <= 21'(rs) * 21'd16384 + 21'd62;
		end
		if (state_q == ST_C4) begin
			qnc_q <= $signed({1'b0, q_fix}) - $signed({13'd0, QNC_OFS});
			va_q  <= va_prod[46:32];
		end
		if (fire) begin
			res_q <= done_res;
		end
	end
endmodule

[rtl/core/albdu_checker.sv]
`timescale 1ns / 1ps
module albdu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [albdu_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready
);
	import albdu_pkg::*;

	logic [2:0] open_q;
	logic       s_xfer;
	logic       m_xfer;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (s_xfer && !m_xfer) begin
			open_q <= open_q + 3'd1;
		end else if (m_xfer && !s_xfer) begin
			open_q <= open_q - 3'd1;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no result without an item in flight
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> open_q != 3'd0)
		else $error("result without a pending item");

	// queue, back end and output register hold at most four items
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q >= 3'd4 |-> !s_tready)
		else $error("input taken beyond capacity");
endmodule

bind snow_albedo_daily_update albdu_checker u_albdu_checker (.*);
